[src/cht_pkg.sv]
`default_nettype none
package cht_pkg;

  // Table geometry (BUCKET_COUNT must be a power of two: the bucket is the
  // low bits of the 64-bit hash, and those depend only on low bits)
  localparam int BUCKET_COUNT  = 1024;
  localparam int WAYS          = 4;
  localparam int MAX_KEY_BYTES = 8;

  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;
  localparam int LEN_W    = 4;
  localparam int BUCKET_W = $clog2(BUCKET_COUNT);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Hash multiplier 31 = 32 - 1
  localparam int HASH_SHIFT = 5;

  // Request codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP,
    ST_RESP
  } cht_state_t;

  // Hash unit control
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } cht_hash_req_t;

  typedef struct packed {
    logic                done;
    logic [BUCKET_W-1:0] bucket;
  } cht_hash_rsp_t;

  // Slot memory ports
  typedef struct packed {
    logic                rd_en;
    logic [BUCKET_W-1:0] addr;
  } cht_rd_t;

  typedef struct packed {
    logic                valid_we;
    logic                data_we;
    logic [WAY_W-1:0]    way;
    logic [BUCKET_W-1:0] addr;
    logic [WAYS-1:0]     valid_row;
    logic [KEY_W-1:0]    key;
    logic [LEN_W-1:0]    len;
    logic [VAL_W-1:0]    value;
  } cht_wr_t;

  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][KEY_W-1:0] key;
    logic [WAYS-1:0][LEN_W-1:0] len;
    logic [WAYS-1:0][VAL_W-1:0] value;
  } cht_row_t;

endpackage
`default_nettype wire

[src/cht_req_if.sv]
`default_nettype none
interface cht_req_if import cht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [KEY_W-1:0] key_bytes;
  logic [LEN_W-1:0] key_length;
  logic [VAL_W-1:0] write_value;

  modport source (output valid, req_type, key_bytes, key_length, write_value,
                  input ready);
  modport sink (input valid, req_type, key_bytes, key_length, write_value,
                output ready);
endinterface
`default_nettype wire

[src/cht_rsp_if.sv]
`default_nettype none
interface cht_rsp_if import cht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [VAL_W-1:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink (input valid, status, read_value, output ready);
endinterface
`default_nettype wire

[src/cht_hash.sv]
`default_nettype none
// Byte-serial hash: h = h*31 + byte, one key byte per cycle, kept to the
// bucket bits (exact modulo for a power-of-two bucket count).
module cht_hash import cht_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cht_hash_req_t hreq,
  output cht_hash_rsp_t      hrsp
);

  logic                busy;
  logic [LEN_W-1:0]    cnt;
  logic [KEY_W-1:0]    key_sr;
  logic [BUCKET_W-1:0] h;
  logic [BUCKET_W-1:0] h_next;

  // shared step: shift-subtract multiply by 31, then add the byte
  assign h_next = (h << HASH_SHIFT) - h + BUCKET_W'(key_sr[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (hreq.start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hreq.start) begin
      cnt    <= hreq.len;
      key_sr <= hreq.key;
      h      <= '0;
    end else if (busy && cnt != '0) begin
      cnt    <= cnt - LEN_W'(1);
      key_sr <= key_sr >> 8;
      h      <= h_next;
    end
  end

  assign hrsp.done   = busy && (cnt == '0);
  assign hrsp.bucket = h;

endmodule
`default_nettype wire

[src/cht_slot_mem.sv]
`default_nettype none
// Bucket-row memory: one row holds all ways of a bucket. Registered read
// of a whole row, write of the valid row and/or one way's data.
module cht_slot_mem import cht_pkg::*; (
  input  wire logic    clk,
  input  wire cht_rd_t rd,
  input  wire cht_wr_t wr,
  output cht_row_t     row
);

  logic [WAYS-1:0]  valid_mem [BUCKET_COUNT];
  logic [KEY_W-1:0] key_mem   [WAYS][BUCKET_COUNT];
  logic [LEN_W-1:0] len_mem   [WAYS][BUCKET_COUNT];
  logic [VAL_W-1:0] val_mem   [WAYS][BUCKET_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (wr.valid_we) begin
      valid_mem[wr.addr] <= wr.valid_row;
    end
    if (wr.data_we) begin
      key_mem[wr.way][wr.addr] <= wr.key;
      len_mem[wr.way][wr.addr] <= wr.len;
      val_mem[wr.way][wr.addr] <= wr.value;
    end
  end

  // read port, whole row
  always_ff @(posedge clk) begin
    if (rd.rd_en) begin
      row.valid <= valid_mem[rd.addr];
      for (int g = 0; g < WAYS; g++) begin
        row.key[g]   <= key_mem[g][rd.addr];
        row.len[g]   <= len_mem[g][rd.addr];
        row.value[g] <= val_mem[g][rd.addr];
      end
    end
  end

endmodule
`default_nettype wire

[src/chained_hash_table_engine_unit.sv]
`default_nettype none
// Per request: one hash step per key byte, one row read, one lookup/update,
// then a load into the output register, held off while a previous response
// is stalled. One request at a time: the next is taken once the previous one
// is loaded; the byte-serial hash unit and the bucket row read-modify-write
// set the rate. Reset: synchronous; then a pass over all buckets clears one
// bucket's valid bits per cycle, with req.ready low until it ends.
module chained_hash_table_engine_unit import cht_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  cht_req_if.sink    req,
  cht_rsp_if.source  rsp
);

  cht_state_t state, state_next;

  logic                accept;
  logic [BUCKET_W-1:0] clr_addr;
  logic [LEN_W-1:0]    len_in;
  logic [KEY_W-1:0]    key_in;

  logic [1:0]          op_q;
  logic [KEY_W-1:0]    key_q;
  logic [LEN_W-1:0]    len_q;
  logic [VAL_W-1:0]    wval_q;
  logic [BUCKET_W-1:0] bucket_q;

  logic [1:0]          status_q;
  logic [VAL_W-1:0]    rval_q;
  logic [1:0]          status_c;
  logic [VAL_W-1:0]    rval_c;

  logic                out_valid;
  logic [1:0]          out_status;
  logic [VAL_W-1:0]    out_value;

  cht_hash_req_t hreq;
  cht_hash_rsp_t hrsp;
  cht_rd_t       rd;
  cht_wr_t       wr;
  cht_row_t      row;

  logic             found, have_free;
  logic [WAY_W-1:0] hit_way, free_way;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // clamp length, zero bytes beyond it
  always_comb begin
    len_in = (req.key_length > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES)
                                                      : req.key_length;
    for (int i = 0; i < KEY_W / 8; i++) begin
      key_in[8*i +: 8] = (LEN_W'(i) < len_in) ? req.key_bytes[8*i +: 8] : 8'h00;
    end
  end

  cht_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .hreq (hreq),
    .hrsp (hrsp)
  );

  cht_slot_mem u_mem (
    .clk (clk),
    .rd  (rd),
    .wr  (wr),
    .row (row)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.req_type;
      key_q  <= key_in;
      len_q  <= len_in;
      wval_q <= req.write_value;
    end
    if (hrsp.done && state == ST_HASH) begin
      bucket_q <= hrsp.bucket;
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + BUCKET_W'(1);
    end
  end

  // way match and first free way, lowest way wins
  always_comb begin
    found     = 1'b0;
    have_free = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row.valid[w]) begin
        if (!found && row.len[w] == len_q && row.key[w] == key_q) begin
          found   = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_way  = WAY_W'(w);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == BUCKET_W'(BUCKET_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_HASH;
      ST_HASH:   if (hrsp.done) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_RESP;
      ST_RESP:   if (!out_valid || rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // outputs of the sequencer
  always_comb begin
    hreq.start = accept;
    hreq.key   = key_in;
    hreq.len   = len_in;

    rd.rd_en = (state == ST_HASH) && hrsp.done;
    rd.addr  = hrsp.bucket;

    wr.valid_we  = 1'b0;
    wr.data_we   = 1'b0;
    wr.way       = '0;
    wr.addr      = bucket_q;
    wr.valid_row = row.valid;
    wr.key       = key_q;
    wr.len       = len_q;
    wr.value     = wval_q;

    status_c = STATUS_NOT_FOUND;
    rval_c   = '0;

    unique case (state)
      ST_CLEAR: begin
        wr.valid_we  = 1'b1;
        wr.addr      = clr_addr;
        wr.valid_row = '0;
      end
      ST_LOOKUP: begin
        unique case (op_q)
          OP_INSERT: begin
            if (found) begin
              wr.data_we = 1'b1;
              wr.way     = hit_way;
              status_c   = STATUS_OK;
            end else if (have_free) begin
              wr.valid_we  = 1'b1;
              wr.valid_row = row.valid | (WAYS'(1) << free_way);
              wr.data_we   = 1'b1;
              wr.way       = free_way;
              status_c     = STATUS_OK;
            end else begin
              status_c = STATUS_FULL;
            end
          end
          OP_SEARCH: begin
            if (found) begin
              status_c = STATUS_OK;
              rval_c   = row.value[hit_way];
            end
          end
          OP_DELETE: begin
            if (found) begin
              wr.valid_we  = 1'b1;
              wr.valid_row = row.valid & ~(WAYS'(1) << hit_way);
              status_c     = STATUS_OK;
            end
          end
          default: begin
            status_c = STATUS_NOT_FOUND;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // lookup result
  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      status_q <= status_c;
      rval_q   <= rval_c;
    end
  end

  // output register; next request may be taken while a beat waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && (!out_valid || rsp.ready)) begin
      out_status <= status_q;
      out_value  <= rval_q;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_value;

endmodule
`default_nettype wire

[src/cht_checker.sv]
`default_nettype none
module cht_checker import cht_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic [1:0]       rsp_status,
  input wire logic [VAL_W-1:0] rsp_read_value
);

  // clear pass keeps requests out right after reset
  a_clear_busy: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready during clear pass");

  // one request in flight: busy after each accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in flight");

  // response beat holds while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                && $stable(rsp_read_value))
    else $error("response beat changed while stalled");

  // only known status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NOT_FOUND
                   || rsp_status == STATUS_FULL))
    else $error("unknown status code");

  // value is zero unless a hit
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STATUS_OK |-> rsp_read_value == '0)
    else $error("nonzero read value without a hit");

endmodule

bind chained_hash_table_engine_unit cht_checker u_cht_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_read_value (rsp.read_value)
);
`default_nettype wire

[dv/cht_table_checker.sv]
`default_nettype none
// Watches the request and response channels, keeps a shadow copy of the
// bucket table and checks every response beat against the predicted one.
module cht_table_checker import cht_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  cht_req_if        req,
  cht_rsp_if        rsp,
  output int        fail_count,
  output int        pending_count
);

  localparam int NUM_SLOTS  = BUCKET_COUNT * WAYS;
  localparam int KEY_BYTES  = KEY_W / 8;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] read_value;
  } cht_result_t;

  // Shadow table, slot = bucket*WAYS + way
  logic             shadow_valid [NUM_SLOTS];
  logic [KEY_W-1:0] shadow_key   [NUM_SLOTS];
  logic [LEN_W-1:0] shadow_len   [NUM_SLOTS];
  logic [VAL_W-1:0] shadow_value [NUM_SLOTS];

  // Responses still owed by the block, oldest first
  cht_result_t owed_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  // h = h*31 + byte over the key bytes, 64-bit wrap, then modulo bucket count
  function automatic int unsigned key_bucket(input logic [KEY_W-1:0] key,
                                             input int unsigned nbytes);
    logic [63:0] h;
    h = '0;
    for (int i = 0; i < nbytes; i++)
      h = h * 64'd31 + {56'd0, key[8*i +: 8]};
    return int'(h % 64'(BUCKET_COUNT));
  endfunction

  // Apply one request to the shadow table and return the response it owes
  function automatic cht_result_t apply_table_op(input logic [1:0]       op,
                                                 input logic [KEY_W-1:0] raw_key,
                                                 input logic [LEN_W-1:0] raw_len,
                                                 input logic [VAL_W-1:0] wval);
    int unsigned nbytes;
    logic [KEY_W-1:0] key;
    int base;
    int hit;
    int free_slot;
    bit found;
    bit have_free;
    cht_result_t res;
    // over-long keys are clamped; bytes past the length do not count
    nbytes = (raw_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : raw_len;
    key    = raw_key;
    if (nbytes < KEY_BYTES)
      key = raw_key & ((64'd1 << (8 * nbytes)) - 64'd1);
    base      = key_bucket(key, nbytes) * WAYS;
    hit       = 0;
    free_slot = 0;
    found     = 1'b0;
    have_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (!found && shadow_len[base + w] == LEN_W'(nbytes) &&
            shadow_key[base + w] == key) begin
          found = 1'b1;
          hit   = base + w;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = base + w;
      end
    end
    res.status     = STATUS_NOT_FOUND;
    res.read_value = '0;
    case (op)
      OP_INSERT: begin
        if (found) begin
          shadow_value[hit] = wval;
          res.status        = STATUS_OK;
        end else if (have_free) begin
          shadow_valid[free_slot] = 1'b1;
          shadow_key[free_slot]   = key;
          shadow_len[free_slot]   = LEN_W'(nbytes);
          shadow_value[free_slot] = wval;
          res.status              = STATUS_OK;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      OP_SEARCH: begin
        if (found) begin
          res.status     = STATUS_OK;
          res.read_value = shadow_value[hit];
        end
      end
      OP_DELETE: begin
        if (found) begin
          shadow_valid[hit] = 1'b0;
          res.status        = STATUS_OK;
        end
      end
      default: ;  // unknown opcode: table untouched, not_found
    endcase
    return res;
  endfunction

  // Response beats are checked before the request beat of the same edge
  always @(posedge clk) begin : monitor
    cht_result_t want;
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++)
        shadow_valid[s] = 1'b0;
      owed_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          report_error($sformatf("response beat with nothing owed: status=%0d value=%h",
                                 rsp.status, rsp.read_value));
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status)
            report_error($sformatf("status: expected %0d, got %0d",
                                   want.status, rsp.status));
          if (rsp.read_value !== want.read_value)
            report_error($sformatf("read_value: expected %h, got %h",
                                   want.read_value, rsp.read_value));
        end
      end
      if (req.valid && req.ready)
        owed_results.insert(owed_results.size(),
                            apply_table_op(req.req_type, req.key_bytes,
                                           req.key_length, req.write_value));
    end
    pending_count <= owed_results.size();
  end

endmodule
`default_nettype wire

[dv/tb_chained_hash_table_engine_unit.sv]
`default_nettype none
module tb_chained_hash_table_engine_unit;
  import cht_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam int RANDOM_ITEMS  = 1030;
  localparam int HOLD_AT       = 300;   // receiver long hold-off starts here
  localparam int DRAIN_AT      = 600;   // sender waits for every response here
  localparam int QUIET_AT      = 900;   // no idling from here on
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_LIMIT    = 5000;  // covers the clear pass after reset
  localparam int TAIL_CYCLES   = 20;
  localparam int POOL_MAX      = 64;
  localparam int GROUP_KEYS    = 6;     // more than WAYS, so the bucket overflows

  logic clk;
  logic rst;

  cht_req_if req_ch ();
  cht_rsp_if rsp_ch ();

  int fail_count;
  int pending_count;

  logic bursts_on  = 1'b1;
  logic hold_armed = 1'b0;
  int   items_sent = 0;
  int   idle_cycles = 0;

  // Keys seen so far, reused to get hits, updates and deletes
  logic [KEY_W-1:0] pool_key [$];
  logic [LEN_W-1:0] pool_len [$];

  chained_hash_table_engine_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  cht_table_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response side: random stalls, one long hold-off once armed
  initial begin : rsp_side
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_armed && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic void remember_key(input logic [KEY_W-1:0] key,
                                       input logic [LEN_W-1:0] len);
    int idx;
    if (pool_key.size() < POOL_MAX) begin
      pool_key.insert(pool_key.size(), key);
      pool_len.insert(pool_len.size(), len);
    end else begin
      idx = $urandom_range(0, POOL_MAX - 1);
      pool_key[idx] = key;
      pool_len[idx] = len;
    end
  endfunction

  // Offer one request beat, with an optional gap in front of it
  task automatic send_request(input logic [1:0]       op,
                              input logic [KEY_W-1:0] key,
                              input logic [LEN_W-1:0] len,
                              input logic [VAL_W-1:0] value);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= op;
    req_ch.key_bytes   <= key;
    req_ch.key_length  <= len;
    req_ch.write_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_all_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Random operation on a known key (with junk past its length) or a fresh one
  task automatic random_request();
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      nbytes;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = OP_INSERT;
    else if (pick < 70) op = OP_SEARCH;
    else if (pick < 92) op = OP_DELETE;
    else                op = OP_UNKNOWN;
    if (pool_key.size() != 0 && $urandom_range(0, 99) < 60) begin
      idx    = $urandom_range(0, pool_key.size() - 1);
      key    = pool_key[idx];
      len    = pool_len[idx];
      nbytes = (len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len;
      if ($urandom_range(0, 1) == 1)
        key = key ^ (rand64() << (8 * nbytes));
      if (nbytes == MAX_KEY_BYTES && $urandom_range(0, 3) == 0)
        len = LEN_W'($urandom_range(MAX_KEY_BYTES, (1 << LEN_W) - 1));
    end else begin
      if ($urandom_range(0, 9) == 0)
        len = LEN_W'($urandom_range(MAX_KEY_BYTES + 1, (1 << LEN_W) - 1));
      else
        len = LEN_W'($urandom_range(0, MAX_KEY_BYTES));
      key = rand64();
      remember_key(key, len);
    end
    send_request(op, key, len, pick_value());
  endtask

  // Two-byte keys (b0+i, b1-31i) all hash to 31*b0+b1: fill and overflow one bucket
  task automatic collision_group();
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [KEY_W-1:0] key;
    int               j;
    logic [1:0]       op;
    b0 = 8'($urandom_range(0, 255 - GROUP_KEYS));
    b1 = 8'($urandom_range(31 * (GROUP_KEYS - 1), 255));
    for (int i = 0; i < GROUP_KEYS; i++) begin
      key = {48'd0, 8'(b1 - 31 * i), 8'(b0 + i)};
      remember_key(key, LEN_W'(2));
      send_request(OP_INSERT, key, LEN_W'(2), pick_value());
    end
    for (int i = 0; i < 3; i++) begin
      j   = $urandom_range(0, GROUP_KEYS - 1);
      key = {48'd0, 8'(b1 - 31 * j), 8'(b0 + j)};
      op  = ($urandom_range(0, 1) == 1) ? OP_SEARCH : OP_DELETE;
      send_request(op, key, LEN_W'(2), pick_value());
    end
  endtask

  initial begin : stimulus
    bit drained;
    drained = 1'b0;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= OP_INSERT;
    req_ch.key_bytes   <= '0;
    req_ch.key_length  <= '0;
    req_ch.write_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, zero keys of several lengths share bucket 0
    send_request(OP_SEARCH, '0, LEN_W'(0), rand64());
    send_request(OP_DELETE, 64'h1234, LEN_W'(2), rand64());
    for (int l = 0; l <= WAYS; l++)
      send_request(OP_INSERT, '0, LEN_W'(l), rand64());  // last one overflows
    send_request(OP_INSERT, '0, LEN_W'(0), '1);          // update in place
    send_request(OP_SEARCH, '1, LEN_W'(0), '0);          // empty key ignores all bytes
    send_request(OP_SEARCH, '0, LEN_W'(WAYS + 1), '0);   // length mismatch
    send_request(OP_DELETE, '0, LEN_W'(1), '0);
    send_request(OP_INSERT, '0, LEN_W'(WAYS), '0);       // reuses the freed way
    // over-long length behaves as full length
    send_request(OP_INSERT, '1, '1, '0);
    send_request(OP_SEARCH, '1, LEN_W'(MAX_KEY_BYTES), '1);
    // junk above the key length is ignored
    send_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFAB, LEN_W'(1), rand64());
    send_request(OP_SEARCH, 64'h0000_0000_0000_00AB, LEN_W'(1), '0);
    send_request(OP_UNKNOWN, 64'h0000_0000_0000_00AB, LEN_W'(1), '1);
    send_request(OP_DELETE, 64'h0000_0000_5A5A_00AB, LEN_W'(1), '0);
    send_request(OP_SEARCH, 64'h0000_0000_0000_00AB, LEN_W'(1), '0);
    send_request(OP_DELETE, '1, LEN_W'(MAX_KEY_BYTES + 1), '0);
    send_request(OP_SEARCH, '0, LEN_W'(0), '0);

    // Random traffic with pressure points along the way
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= HOLD_AT && !hold_armed)
        hold_armed <= 1'b1;
      if (items_sent >= DRAIN_AT && !drained) begin
        drained = 1'b1;
        wait_all_responses();
      end
      if (items_sent >= QUIET_AT && bursts_on)
        bursts_on <= 1'b0;
      if ($urandom_range(0, 99) < 6)
        collision_group();
      else
        random_request();
    end

    // Wind down and give the verdict
    wait_all_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
